// ===== src/brf_pkg.sv =====
package brf_pkg;

    localparam int DEPTH = 1024;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CAP_W = 11;
    localparam int LEN_W = 16;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;
    localparam int CNT_W = CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_OVERWRITE = 2'd2;
    localparam logic [1:0] MODE_REJECT = 2'd3;

    localparam logic [STAT_W-1:0] ST_STORED = 3'd0;
    localparam logic [STAT_W-1:0] ST_SKIPPED = 3'd1;
    localparam logic [STAT_W-1:0] ST_REJECTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_READ_OK = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic load;
        logic exec;
        logic fetch_done;
    } t_cmd;

    typedef struct packed {
        logic read_hit;
    } t_stat;

    function automatic logic [PTR_W-1:0] brf_adv(logic [PTR_W-1:0] p, logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] n;
        n = CAP_W'(p) + CAP_W'(1);
        return (n >= cap) ? '0 : n[PTR_W-1:0];
    endfunction

    function automatic logic [CAP_W-1:0] brf_clamp(logic [CAP_W-1:0] c);
        if (c == '0) begin
            return CAP_W'(1);
        end else if (c > CAP_W'(DEPTH)) begin
            return CAP_W'(DEPTH);
        end
        return c;
    endfunction

endpackage

// ===== src/byte_ring_fifo_block_write.sv =====
// Channel   Direction  Handshake                 Payload
// s (in)    input      i_s_tvalid / o_s_tready   tdata: burst_len, data_byte; tuser: kind, first
// m (out)   output     o_m_tvalid / i_m_tready   tdata: read_data, level; tuser: status
// apb cfg   input      psel, penable, pwrite     capacity at byte address 0
//
// A write byte or an empty read is held in the input register, then executed into the output
// register; a successful read adds a fetch state for the byte store's registered read port.
// The controller works on one item at a time; a new item is taken while the previous
// result still waits in the output register, and execution holds until that register drains.
// Reset is synchronous and clears pointers, fill count and burst state; the store is not cleared.
module byte_ring_fifo_block_write (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // burst_len [15:0], data_byte [23:16]
    input  logic [1:0]  i_s_tuser,   // kind [0], first_of_burst [1]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // read_data [7:0], level [18:8], zero [23:19]
    output logic [2:0]  o_m_tuser,   // status [2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import brf_pkg::*;

    logic [CAP_W-1:0]  r_cap;
    t_cmd              cmd;
    t_stat             stat;
    logic [BYTE_W-1:0] read_data;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  level;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {(32 - CAP_W)'(0), r_cap} : '0;

    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    brf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_kind      (i_s_tuser[0]),
        .i_first     (i_s_tuser[1]),
        .i_blen      (i_s_tdata[15:0]),
        .i_data      (i_s_tdata[23:16]),
        .i_cap       (r_cap),
        .o_read_data (read_data),
        .o_status    (status),
        .o_level     (level)
    );

    assign o_m_tdata = {(24 - BYTE_W - CNT_W)'(0), level, read_data};
    assign o_m_tuser = status;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (level <= CNT_W'(DEPTH)))
        else $error("level beyond store depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (status == ST_EMPTY)) |-> ((level == '0) && (read_data == '0)))
        else $error("empty read with data or level");

    a_write_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && ((status == ST_STORED) || (status == ST_SKIPPED) ||
            (status == ST_REJECTED))) |-> (read_data == '0))
        else $error("write result carries read data");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second item taken while one is in progress");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (status <= ST_EMPTY))
        else $error("undefined status code");

endmodule

// ===== src/brf_ram.sv =====
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/brf_ctrl.sv =====
module brf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output brf_pkg::t_cmd o_cmd,
    input  brf_pkg::t_stat i_stat
);
    import brf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    t_cmd       cmd;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.exec = 1'b1;
                    if (i_stat.read_hit) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_IDLE;
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                cmd.fetch_done = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd = cmd;

endmodule

// ===== src/brf_dp.sv =====
module brf_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  brf_pkg::t_cmd                i_cmd,
    output brf_pkg::t_stat               o_stat,
    input  logic                         i_kind,
    input  logic                         i_first,
    input  logic [brf_pkg::LEN_W-1:0]    i_blen,
    input  logic [brf_pkg::BYTE_W-1:0]   i_data,
    input  logic [brf_pkg::CAP_W-1:0]    i_cap,
    output logic [brf_pkg::BYTE_W-1:0]   o_read_data,
    output logic [brf_pkg::STAT_W-1:0]   o_status,
    output logic [brf_pkg::CNT_W-1:0]    o_level
);
    import brf_pkg::*;

    logic              r_kind;
    logic              r_first;
    logic [LEN_W-1:0]  r_blen;
    logic [BYTE_W-1:0] r_data;

    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W-1:0]  r_wp;
    logic [CNT_W-1:0]  r_fill;
    logic [1:0]        r_mode;
    logic [LEN_W-1:0]  r_skip;
    logic [PTR_W-1:0]  n_rp;
    logic [PTR_W-1:0]  n_wp;
    logic [CNT_W-1:0]  n_fill;
    logic [1:0]        n_mode;
    logic [LEN_W-1:0]  n_skip;

    logic [BYTE_W-1:0] r_out_data;
    logic [STAT_W-1:0] r_out_status;
    logic [CNT_W-1:0]  r_out_level;

    logic [CAP_W-1:0]  cap;
    logic [LEN_W-1:0]  blen1;
    logic [STAT_W-1:0] status;
    logic              read_hit;
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0] ram_rdata;

    assign cap = brf_clamp(i_cap);
    assign blen1 = (r_blen == '0) ? LEN_W'(1) : r_blen;
    assign read_hit = r_kind && (r_fill != '0);

    always_comb begin
        n_rp = r_rp;
        n_wp = r_wp;
        n_fill = r_fill;
        n_mode = r_mode;
        n_skip = r_skip;
        ram_we = 1'b0;
        ram_waddr = r_wp;
        status = ST_REJECTED;
        if (r_kind) begin
            if (r_fill == '0) begin
                status = ST_EMPTY;
            end else begin
                n_rp = brf_adv(r_rp, cap);
                n_fill = r_fill - CNT_W'(1);
                if (r_fill == CNT_W'(1)) begin
                    n_rp = '0;
                    n_wp = '0;
                end
                status = ST_READ_OK;
            end
        end else if (r_first || (r_mode != MODE_NONE)) begin
            if (r_first) begin
                if (blen1 >= LEN_W'(cap)) begin
                    n_mode = MODE_OVERWRITE;
                    n_rp = '0;
                    n_wp = '0;
                    n_fill = '0;
                end else if ((LEN_W'(r_fill) + blen1) > LEN_W'(cap)) begin
                    n_mode = MODE_REJECT;
                end else begin
                    n_mode = MODE_APPEND;
                end
                n_skip = blen1 - LEN_W'(1);
            end else begin
                n_skip = r_skip - LEN_W'(1);
            end
            if (n_mode == MODE_REJECT) begin
                status = ST_REJECTED;
            end else if ((n_mode == MODE_OVERWRITE) && (n_skip >= LEN_W'(cap))) begin
                status = ST_SKIPPED;
            end else if (n_fill >= cap) begin
                status = ST_REJECTED;
            end else begin
                ram_we = 1'b1;
                ram_waddr = n_wp;
                n_wp = brf_adv(n_wp, cap);
                n_fill = n_fill + CNT_W'(1);
                status = ST_STORED;
            end
            if (n_skip == '0) begin
                n_mode = MODE_NONE;
            end
        end
    end

    brf_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_data),
        .i_re    (i_cmd.exec && read_hit),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= '0;
            r_wp <= '0;
            r_fill <= '0;
            r_mode <= MODE_NONE;
            r_skip <= '0;
        end else if (i_cmd.exec) begin
            r_rp <= n_rp;
            r_wp <= n_wp;
            r_fill <= n_fill;
            r_mode <= n_mode;
            r_skip <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_first <= i_first;
            r_blen <= i_blen;
            r_data <= i_data;
        end
        if (i_cmd.exec) begin
            r_out_data <= '0;
            r_out_status <= status;
            r_out_level <= n_fill;
        end else if (i_cmd.fetch_done) begin
            r_out_data <= ram_rdata;
        end
    end

    assign o_stat.read_hit = read_hit;
    assign o_read_data = r_out_data;
    assign o_status = r_out_status;
    assign o_level = r_out_level;

endmodule
